// ===== rtl/core/stq_pkg.sv =====
`default_nettype none
package stq_pkg;

    // request codes at the input
    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_KILL     = 3'd1;
    localparam logic [2:0] REQ_KILL_ALL = 3'd2;
    localparam logic [2:0] REQ_ADVANCE  = 3'd3;
    localparam logic [2:0] REQ_QUERY    = 3'd4;

    // status codes of a result
    localparam logic [2:0] STATUS_DONE    = 3'd0;
    localparam logic [2:0] STATUS_FULL    = 3'd1;
    localparam logic [2:0] STATUS_FIRED   = 3'd2;
    localparam logic [2:0] STATUS_ANSWER  = 3'd3;
    localparam logic [2:0] STATUS_EMPTY   = 3'd4;

    // most expired entries emitted for one advance
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned FIRE_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_KILL,
        OP_KILL_ALL,
        OP_ADVANCE,
        OP_QUERY,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KILL,
        ST_EXPIRE
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  target_id;
        logic [31:0] cookie;
        logic [30:0] timeout_ms;
        logic [9:0]  delta_ms;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  fired_target;
        logic [31:0] fired_cookie;
        logic [30:0] remaining_ms;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/stq_fifo.sv =====
`default_nettype none
module stq_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/stq_engine.sv =====
`default_nettype none
module stq_engine #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire stq_pkg::cmd_t  cmd,
    output logic                cmd_pop,
    output logic                res_push,
    output stq_pkg::result_t    res,
    input  wire logic           res_full
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [31:0]            due_reg [DEPTH];
    logic [7:0]             tgt_reg [DEPTH];
    logic [31:0]            ck_reg  [DEPTH];
    logic [CW-1:0]          count_reg, count_next;
    logic [31:0]            now_reg, now_next;
    stq_pkg::state_t        state_reg, state_next;
    stq_pkg::cmd_t          cur_reg, cur_next;
    logic [stq_pkg::FIRE_W-1:0] nfire_reg, nfire_next;

    logic [DEPTH-1:0]       valid;
    logic [DEPTH-1:0]       le_new;
    logic [DEPTH-1:0]       kill_hit;
    logic [IW-1:0]          ins_idx;
    logic [IW-1:0]          kill_idx;
    logic                   any_kill;
    logic                   ins_en;
    logic                   rm_en;
    logic [IW-1:0]          rm_idx;
    logic [31:0]            new_due;
    logic [31:0]            head_rel;
    logic [31:0]            second_rel;
    logic                   head_due;
    logic                   second_due;
    logic                   is_full;
    logic                   fire_last;

    // per-entry compares against the new item and the kill key
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid[i]    = (CW'(i) < count_reg);
            le_new[i]   = valid[i] &&
                          ($signed(due_reg[i] - now_reg) <= $signed({1'b0, cmd.timeout_ms}));
            kill_hit[i] = valid[i] && (tgt_reg[i] == cur_reg.target_id) &&
                          ((cur_reg.op == stq_pkg::OP_KILL_ALL) || (ck_reg[i] == cur_reg.cookie));
        end
    end

    // insert slot and first kill match
    always_comb
    begin
        ins_idx  = '0;
        kill_idx = '0;
        any_kill = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!le_new[i])
            begin
                ins_idx = IW'(i);
            end
            if (kill_hit[i])
            begin
                kill_idx = IW'(i);
                any_kill = 1'b1;
            end
        end
    end

    assign is_full    = (count_reg == CW'(DEPTH));
    assign new_due    = now_reg + {1'b0, cmd.timeout_ms};
    assign head_rel   = due_reg[0] - now_reg;
    assign second_rel = due_reg[(DEPTH > 1) ? 1 : 0] - now_reg;
    assign head_due   = (count_reg != '0) && ($signed(head_rel) <= 0);
    assign second_due = (count_reg > CW'(1)) && ($signed(second_rel) <= 0);
    assign fire_last  = !((nfire_reg < stq_pkg::FIRE_W'(stq_pkg::MAX_RESULTS - 1)) && second_due);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == stq_pkg::OP_KILL || cmd.op == stq_pkg::OP_KILL_ALL)
                    begin
                        state_next = stq_pkg::ST_KILL;
                    end
                    else if (cmd.op == stq_pkg::OP_ADVANCE)
                    begin
                        state_next = stq_pkg::ST_EXPIRE;
                    end
                end
            end
            stq_pkg::ST_KILL:
            begin
                if (!any_kill && !res_full)
                begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_EXPIRE:
            begin
                if (!res_full && (!head_due || fire_last))
                begin
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        res.status = stq_pkg::STATUS_DONE;
        res.last   = 1'b1;
        ins_en     = 1'b0;
        rm_en      = 1'b0;
        rm_idx     = '0;
        now_next   = now_reg;
        cur_next   = cur_reg;
        nfire_next = nfire_reg;
        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        stq_pkg::OP_INSERT:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop  = 1'b1;
                                res_push = 1'b1;
                                if (is_full)
                                begin
                                    res.status = stq_pkg::STATUS_FULL;
                                end
                                else
                                begin
                                    ins_en = 1'b1;
                                end
                            end
                        end
                        stq_pkg::OP_KILL, stq_pkg::OP_KILL_ALL:
                        begin
                            cmd_pop  = 1'b1;
                            cur_next = cmd;
                        end
                        stq_pkg::OP_ADVANCE:
                        begin
                            cmd_pop    = 1'b1;
                            now_next   = now_reg + 32'(cmd.delta_ms);
                            nfire_next = '0;
                        end
                        stq_pkg::OP_QUERY:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop  = 1'b1;
                                res_push = 1'b1;
                                if (count_reg == '0)
                                begin
                                    res.status = stq_pkg::STATUS_EMPTY;
                                end
                                else
                                begin
                                    res.status       = stq_pkg::STATUS_ANSWER;
                                    res.remaining_ms = head_rel[31] ? 31'd0 : head_rel[30:0];
                                end
                            end
                        end
                        default:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop  = 1'b1;
                                res_push = 1'b1;
                            end
                        end
                    endcase
                end
            end
            stq_pkg::ST_KILL:
            begin
                // one matching entry removed per cycle
                if (any_kill)
                begin
                    rm_en  = 1'b1;
                    rm_idx = kill_idx;
                end
                else if (!res_full)
                begin
                    res_push = 1'b1;
                end
            end
            stq_pkg::ST_EXPIRE:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (head_due)
                    begin
                        res.status       = stq_pkg::STATUS_FIRED;
                        res.fired_target = tgt_reg[0];
                        res.fired_cookie = ck_reg[0];
                        res.last         = fire_last;
                        rm_en            = 1'b1;
                        nfire_next       = nfire_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ins_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rm_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stq_pkg::ST_IDLE;
            count_reg <= '0;
            now_reg   <= '0;
            nfire_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            now_reg   <= now_next;
            nfire_reg <= nfire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // sorted entry row: shift up on insert, shift down on removal
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        always_ff @(posedge clk)
        begin
            if (rm_en && (IW'(g) >= rm_idx))
            begin
                if (g < DEPTH - 1)
                begin
                    due_reg[g] <= due_reg[(g < DEPTH - 1) ? g + 1 : g];
                    tgt_reg[g] <= tgt_reg[(g < DEPTH - 1) ? g + 1 : g];
                    ck_reg[g]  <= ck_reg[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
            else if (ins_en)
            begin
                if (IW'(g) == ins_idx)
                begin
                    due_reg[g] <= new_due;
                    tgt_reg[g] <= cmd.target_id;
                    ck_reg[g]  <= cmd.cookie;
                end
                else if ((g > 0) && (IW'(g) > ins_idx))
                begin
                    due_reg[g] <= due_reg[(g > 0) ? g - 1 : 0];
                    tgt_reg[g] <= tgt_reg[(g > 0) ? g - 1 : 0];
                    ck_reg[g]  <= ck_reg[(g > 0) ? g - 1 : 0];
                end
            end
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result transfer into a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command pop without command");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfire_reg <= stq_pkg::FIRE_W'(stq_pkg::MAX_RESULTS))
        else $error("too many expiries for one advance");

    a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |-> !is_full)
        else $error("insert into a full row");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_timer_queue.sv =====
// Sorted timer queue: holds up to DEPTH timers ordered by due time, ties kept
// in request order. The request code is decoded on entry and the command goes
// into a two-entry command queue; an engine with a shifting row of entry
// registers carries it out, and results leave through a two-entry result
// queue. A command passes through the registers of the command queue before it
// reaches the engine, and a result through those of the result queue before it
// is on the output ports. Insert and query are carried out in the idle state;
// kill and kill-all remove the matching entries one by one and then report
// done; advance emits one result per expired entry (at most 16), or a done
// result when nothing is due. The entry row moves by one place per cycle, and
// a full result queue stalls the engine.
`default_nettype none
module sorted_timer_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  req_type,
    input  wire logic [7:0]  target_id,
    input  wire logic [31:0] cookie,
    input  wire logic [30:0] timeout_ms,
    input  wire logic [9:0]  delta_ms,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       status,
    output logic [7:0]       fired_target,
    output logic [31:0]      fired_cookie,
    output logic [30:0]      remaining_ms,
    output logic             last
);

    stq_pkg::cmd_t    in_cmd;
    stq_pkg::cmd_t    q_cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_push;
    logic             res_full;
    stq_pkg::result_t eng_res;
    stq_pkg::result_t out_res;

    // classify the request code
    always_comb
    begin
        in_cmd.target_id  = target_id;
        in_cmd.cookie     = cookie;
        in_cmd.timeout_ms = timeout_ms;
        in_cmd.delta_ms   = delta_ms;
        case (req_type)
            stq_pkg::REQ_INSERT:   in_cmd.op = stq_pkg::OP_INSERT;
            stq_pkg::REQ_KILL:     in_cmd.op = stq_pkg::OP_KILL;
            stq_pkg::REQ_KILL_ALL: in_cmd.op = stq_pkg::OP_KILL_ALL;
            stq_pkg::REQ_ADVANCE:  in_cmd.op = stq_pkg::OP_ADVANCE;
            stq_pkg::REQ_QUERY:    in_cmd.op = stq_pkg::OP_QUERY;
            default:               in_cmd.op = stq_pkg::OP_NOP;
        endcase
    end

    // command queue
    stq_fifo #(
        .WIDTH($bits(stq_pkg::cmd_t))
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (q_cmd),
        .empty   (cmd_empty)
    );

    stq_engine #(
        .DEPTH(DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (q_cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (eng_res),
        .res_full  (res_full)
    );

    // result queue
    stq_fifo #(
        .WIDTH($bits(stq_pkg::result_t))
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (eng_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign status       = out_res.status;
    assign fired_target = out_res.fired_target;
    assign fired_cookie = out_res.fired_cookie;
    assign remaining_ms = out_res.remaining_ms;
    assign last         = out_res.last;

endmodule
`default_nettype wire

// ===== tb/tb_sorted_timer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_timer_queue;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  fired_target;
        logic [31:0] fired_cookie;
        logic [30:0] remaining_ms;
        logic        last;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  req_type;
    logic [7:0]  target_id;
    logic [31:0] cookie;
    logic [30:0] timeout_ms;
    logic [9:0]  delta_ms;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [7:0]  fired_target;
    logic [31:0] fired_cookie;
    logic [30:0] remaining_ms;
    logic        last;

    // predictor state
    logic [31:0] timer_due[DEPTH];
    logic [7:0]  timer_target[DEPTH];
    logic [31:0] timer_cookie[DEPTH];
    int          timer_count;
    logic [31:0] clock_ms;

    answer_t pending_answers[$];
    int      fail_count;
    int      idle_cycles;
    bit      send_noidle;
    bit      recv_noidle;
    bit      recv_hold;
    int      recv_hold_cycles;
    logic [7:0] recent_targets[$];
    logic [31:0] recent_cookies[$];

    sorted_timer_queue #(.DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .target_id(target_id), .cookie(cookie),
        .timeout_ms(timeout_ms), .delta_ms(delta_ms), .empty(empty), .pop(pop),
        .status(status), .fired_target(fired_target),
        .fired_cookie(fired_cookie), .remaining_ms(remaining_ms), .last(last)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] due_key(logic [31:0] due);
        return (due - clock_ms) ^ 32'h8000_0000;
    endfunction

    function automatic void queue_answer(logic [2:0] st, logic [7:0] tg,
                                         logic [31:0] ck, logic [30:0] rem,
                                         logic lst);
        answer_t a;
        a.status = st;
        a.fired_target = tg;
        a.fired_cookie = ck;
        a.remaining_ms = rem;
        a.last = lst;
        pending_answers.push_back(a);
    endfunction

    // compute the answers of one request and update the timer list
    function automatic void predict_timers(logic [2:0] rt, logic [7:0] tg,
                                           logic [31:0] ck, logic [30:0] tmo,
                                           logic [9:0] dlt);
        logic [31:0] due;
        logic [31:0] diff;
        int pos;
        int w;
        int n;
        bit hit;
        case (rt)
            stq_pkg::REQ_INSERT:
            begin
                if (timer_count >= DEPTH)
                begin
                    queue_answer(stq_pkg::STATUS_FULL, 0, 0, 0, 1'b1);
                end
                else
                begin
                    due = clock_ms + {1'b0, tmo};
                    pos = 0;
                    while (pos < timer_count && due_key(timer_due[pos]) <= due_key(due))
                        pos++;
                    for (int i = timer_count; i > pos; i--)
                    begin
                        timer_due[i] = timer_due[i-1];
                        timer_target[i] = timer_target[i-1];
                        timer_cookie[i] = timer_cookie[i-1];
                    end
                    timer_due[pos] = due;
                    timer_target[pos] = tg;
                    timer_cookie[pos] = ck;
                    timer_count++;
                    queue_answer(stq_pkg::STATUS_DONE, 0, 0, 0, 1'b1);
                end
            end
            stq_pkg::REQ_KILL, stq_pkg::REQ_KILL_ALL:
            begin
                w = 0;
                for (int i = 0; i < timer_count; i++)
                begin
                    hit = (timer_target[i] == tg) &&
                          (rt == stq_pkg::REQ_KILL_ALL || timer_cookie[i] == ck);
                    if (!hit)
                    begin
                        timer_due[w] = timer_due[i];
                        timer_target[w] = timer_target[i];
                        timer_cookie[w] = timer_cookie[i];
                        w++;
                    end
                end
                timer_count = w;
                queue_answer(stq_pkg::STATUS_DONE, 0, 0, 0, 1'b1);
            end
            stq_pkg::REQ_ADVANCE:
            begin
                n = 0;
                clock_ms = clock_ms + dlt;
                while (n < stq_pkg::MAX_RESULTS && timer_count > 0 &&
                       due_key(timer_due[0]) <= 32'h8000_0000)
                begin
                    queue_answer(stq_pkg::STATUS_FIRED, timer_target[0],
                                 timer_cookie[0], 0, 1'b0);
                    n++;
                    for (int i = 1; i < timer_count; i++)
                    begin
                        timer_due[i-1] = timer_due[i];
                        timer_target[i-1] = timer_target[i];
                        timer_cookie[i-1] = timer_cookie[i];
                    end
                    timer_count--;
                end
                if (n == 0)
                    queue_answer(stq_pkg::STATUS_DONE, 0, 0, 0, 1'b1);
                else
                    pending_answers[$].last = 1'b1;
            end
            stq_pkg::REQ_QUERY:
            begin
                if (timer_count == 0)
                begin
                    queue_answer(stq_pkg::STATUS_EMPTY, 0, 0, 0, 1'b1);
                end
                else
                begin
                    diff = timer_due[0] - clock_ms;
                    if (diff[31])
                        diff = 0;
                    queue_answer(stq_pkg::STATUS_ANSWER, 0, 0, diff[30:0], 1'b1);
                end
            end
            default:
                queue_answer(stq_pkg::STATUS_DONE, 0, 0, 0, 1'b1);
        endcase
    endfunction

    // offer one item until it is accepted, with random gaps before it
    task automatic send_request(logic [2:0] rt, logic [7:0] tg, logic [31:0] ck,
                                logic [30:0] tmo, logic [9:0] dlt);
        while (!send_noidle && $urandom_range(99) < 21)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        req_type <= rt;
        target_id <= tg;
        cookie <= ck;
        timeout_ms <= tmo;
        delta_ms <= dlt;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_timers(rt, tg, ck, tmo, dlt);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (pending_answers.size() != 0)
            @(negedge clk);
    endtask

    // receiver side: random pop with optional long hold
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (recv_hold)
        begin
            pop <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles + 1;
            if (recv_hold_cycles >= 300)
                recv_hold <= 1'b0;
        end
        else
        begin
            pop <= recv_noidle || ($urandom_range(99) >= 21);
        end
    end

    // check each result transfer against the oldest expected answer
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && pop && !empty)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result status=%0d", status);
                fail_count++;
            end
            else
            begin
                exp_a = pending_answers[0];
                pending_answers.delete(0);
                if (status !== exp_a.status)
                begin
                    $error("status exp %0d got %0d", exp_a.status, status);
                    fail_count++;
                end
                if (fired_target !== exp_a.fired_target)
                begin
                    $error("fired_target exp %0d got %0d", exp_a.fired_target, fired_target);
                    fail_count++;
                end
                if (fired_cookie !== exp_a.fired_cookie)
                begin
                    $error("fired_cookie exp %h got %h", exp_a.fired_cookie, fired_cookie);
                    fail_count++;
                end
                if (remaining_ms !== exp_a.remaining_ms)
                begin
                    $error("remaining_ms exp %0d got %0d", exp_a.remaining_ms, remaining_ms);
                    fail_count++;
                end
                if (last !== exp_a.last)
                begin
                    $error("last exp %0d got %0d", exp_a.last, last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [30:0] pick_timeout();
        case ($urandom_range(5))
            0: return 0;
            1: return 31'h4000_0000;
            2: return 31'($urandom_range(4000, 1000));
            default: return 31'($urandom_range(900));
        endcase
    endfunction

    // directed: field extremes, every request code, special cases
    task automatic test_directed();
        send_request(stq_pkg::REQ_QUERY, 0, 0, 0, 0);
        send_request(stq_pkg::REQ_ADVANCE, 0, 0, 0, 0);
        send_request(stq_pkg::REQ_INSERT, 8'hFF, 32'hFFFF_FFFF, 31'h4000_0000, 10'h3FF);
        send_request(stq_pkg::REQ_INSERT, 8'h00, 32'h0, 31'd5, 0);
        send_request(stq_pkg::REQ_INSERT, 8'h01, 32'h1, 31'd5, 0);
        send_request(stq_pkg::REQ_INSERT, 8'h02, 32'h2, 31'd0, 0);
        send_request(stq_pkg::REQ_QUERY, 0, 0, 0, 0);
        send_request(stq_pkg::REQ_KILL, 8'h01, 32'h1, 0, 0);
        send_request(stq_pkg::REQ_KILL, 8'h07, 32'h7, 0, 0);
        send_request(3'd5, 8'hAA, 32'h5555_AAAA, 31'h7FFF_FFFF, 10'h3FF);
        send_request(3'd6, 0, 0, 0, 0);
        send_request(3'd7, 0, 0, 0, 0);
        send_request(stq_pkg::REQ_ADVANCE, 0, 0, 0, 10'h3FF);
        send_request(stq_pkg::REQ_KILL_ALL, 8'hFF, 0, 0, 0);
        // fill to the limit, one more is dropped
        for (int i = 0; i < DEPTH + 1; i++)
            send_request(stq_pkg::REQ_INSERT, 8'(i % 3), 32'(i), 31'd10, 0);
        send_request(stq_pkg::REQ_QUERY, 0, 0, 0, 0);
        // all sixteen expire at once, then an advance with nothing due
        send_request(stq_pkg::REQ_ADVANCE, 0, 0, 0, 10'd20);
        send_request(stq_pkg::REQ_ADVANCE, 0, 0, 0, 0);
        // query with one pending timer, then its expiry
        send_request(stq_pkg::REQ_INSERT, 8'h33, 32'h33, 31'd1, 0);
        send_request(stq_pkg::REQ_QUERY, 0, 0, 0, 0);
        send_request(stq_pkg::REQ_ADVANCE, 0, 0, 0, 10'd1);
    endtask

    // random: mostly timer traffic with reuse of recent targets and cookies
    task automatic test_random(int count);
        logic [2:0]  rt;
        logic [7:0]  tg;
        logic [31:0] ck;
        int          sel;
        for (int k = 0; k < count; k++)
        begin
            send_noidle = (k >= count / 2 && k < count / 2 + 30);
            recv_noidle = send_noidle;
            sel = $urandom_range(99);
            tg = 8'($urandom);
            ck = $urandom;
            if (recent_targets.size() != 0 && $urandom_range(1))
            begin
                int j;
                j = $urandom_range(recent_targets.size() - 1);
                tg = recent_targets[j];
                ck = recent_cookies[j];
            end
            if (sel < 45)
                rt = stq_pkg::REQ_INSERT;
            else if (sel < 57)
                rt = stq_pkg::REQ_KILL;
            else if (sel < 63)
                rt = stq_pkg::REQ_KILL_ALL;
            else if (sel < 85)
                rt = stq_pkg::REQ_ADVANCE;
            else if (sel < 96)
                rt = stq_pkg::REQ_QUERY;
            else
                rt = 3'($urandom_range(7, 5));
            if (rt == stq_pkg::REQ_INSERT)
            begin
                tg = 8'($urandom_range(7));
                recent_targets.push_back(tg);
                recent_cookies.push_back(ck);
                if (recent_targets.size() > 12)
                begin
                    recent_targets.delete(0);
                    recent_cookies.delete(0);
                end
            end
            send_request(rt, tg, ck, pick_timeout(), 10'($urandom));
        end
        send_noidle = 0;
        recv_noidle = 0;
    endtask

    // hold the receiver while the sender keeps pushing
    task automatic test_backpressure();
        recv_hold_cycles = 0;
        recv_hold = 1'b1;
        for (int i = 0; i < 10; i++)
            send_request(stq_pkg::REQ_QUERY, 0, 0, 0, 0);
        wait_drained();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        push = 0;
        req_type = 0;
        target_id = 0;
        cookie = 0;
        timeout_ms = 0;
        delta_ms = 0;
        fail_count = 0;
        idle_cycles = 0;
        send_noidle = 0;
        recv_noidle = 0;
        recv_hold = 0;
        recv_hold_cycles = 0;
        timer_count = 0;
        clock_ms = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        wait_drained();
        test_backpressure();
        test_random(113);
        wait_drained();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/stq_pkg.sv
rtl/core/stq_fifo.sv
rtl/core/stq_engine.sv
rtl/core/sorted_timer_queue.sv
tb/tb_sorted_timer_queue.sv
